// ----- hdl/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key/value table
// Capacity, index widths, request and response payloads, codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ENTRY_W  = KEY_W + VAL_W;

    // request kinds
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // response status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DUP     = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [VAL_W-1:0]  found_value;
        logic [4:0]               entries_held;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EXEC,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_NEW,
        ST_REM_RD,
        ST_REM_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/skvt_ram.sv -----
// ----------------------------------------------------------------------------
// skvt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/sorted_key_value_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_key_value_table_top: sorted key/value table
// Ordered table of unique signed keys with values; insert, remove, lookup.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY (16) entries in ascending signed key order in one RAM
// of {key, value} words. Each request transfer is served by a small sequencer
// around that RAM and one shared comparator: a linear ordered search reads one
// entry at a time until it finds the first key not below the request key or
// runs past the last entry, then an insert shifts the later entries up and
// writes the new entry, and a remove shifts the later entries down. Each
// search or shift step reads through the RAM's single read port and waits
// for its registered read data before it compares or writes. req_ready is
// high only while the sequencer is idle. The response sits in an output
// register, so a new request is taken while an earlier response still waits
// for rsp_ready.
// Status: 0 done/found, 1 duplicate key (checked before full), 2 not found or
// unused op, 3 table full. found_value is zero unless a remove or lookup hit.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire skvt_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output skvt_pkg::rsp_t     rsp
);

    import skvt_pkg::*;

    // sequencer state and working registers
    state_t               state_reg,  state_next;
    logic [CNT_W-1:0]     count_reg,  count_next;   // entries held
    logic [CNT_W-1:0]     idx_reg,    idx_next;     // search / shift index
    logic [CNT_W-1:0]     pos_reg,    pos_next;     // ordered slot
    logic                 hit_reg,    hit_next;
    logic [VAL_W-1:0]     hval_reg,   hval_next;    // value of the hit entry
    logic [1:0]           status_reg, status_next;
    logic [VAL_W-1:0]     fval_reg,   fval_next;
    req_t                 req_reg,    req_next;

    // response register
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg,       rsp_next;

    // RAM port
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    logic signed [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0]        rd_val;
    logic                    rsp_free;

    assign rd_key   = rd_data[ENTRY_W-1:VAL_W];
    assign rd_val   = rd_data[VAL_W-1:0];
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    skvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        hval_reg   <= hval_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        logic [CNT_W:0] idx_dec;
        logic [CNT_W:0] idx_inc;
        logic [CNT_W:0] idx_inc2;
        logic [CNT_W:0] pos_inc;

        idx_dec  = {1'b0, idx_reg} - 1'b1;
        idx_inc  = {1'b0, idx_reg} + 1'b1;
        idx_inc2 = {1'b0, idx_reg} + 2'd2;
        pos_inc  = {1'b0, pos_reg} + 1'b1;

        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        hval_next      = hval_reg;
        status_next    = status_reg;
        fval_next      = fval_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        req_ready = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg[ADDR_W-1:0];
        wr_data   = rd_data;
        rd_addr   = idx_reg[ADDR_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end

            ST_SRCH_CMP:
            begin
                if (rd_key < req_reg.key)
                begin
                    idx_next   = idx_inc[CNT_W-1:0];
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    hit_next   = (rd_key == req_reg.key);
                    hval_next  = rd_val;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                status_next = STAT_MISSING;
                fval_next   = '0;
                state_next  = ST_DONE;
                case (req_reg.op)
                    OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STAT_DUP;
                        end
                        else if ({1'b0, count_reg} >= (CNT_W+1)'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            idx_next    = count_reg;
                            state_next  = (count_reg > pos_reg) ? ST_INS_RD : ST_INS_NEW;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STAT_OK;
                            fval_next   = hval_reg;
                            idx_next    = pos_reg;
                            if (pos_inc < {1'b0, count_reg})
                            begin
                                state_next = ST_REM_RD;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STAT_OK;
                            fval_next   = hval_reg;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_MISSING;
                    end
                endcase
            end

            ST_INS_RD:
            begin
                rd_addr    = idx_dec[ADDR_W-1:0];
                state_next = ST_INS_WR;
            end

            ST_INS_WR:
            begin
                // move entry idx-1 up to idx
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = rd_data;
                idx_next = idx_dec[CNT_W-1:0];
                state_next = (idx_dec[CNT_W-1:0] > pos_reg) ? ST_INS_RD : ST_INS_NEW;
            end

            ST_INS_NEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                wr_data    = {req_reg.key, req_reg.value};
                count_next = count_reg + 1'b1;
                state_next = ST_DONE;
            end

            ST_REM_RD:
            begin
                rd_addr    = idx_inc[ADDR_W-1:0];
                state_next = ST_REM_WR;
            end

            ST_REM_WR:
            begin
                // move entry idx+1 down to idx
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = rd_data;
                idx_next = idx_inc[CNT_W-1:0];
                if (idx_inc2 < {1'b0, count_reg})
                begin
                    state_next = ST_REM_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.found_value  = fval_reg;
                    rsp_next.entries_held = 5'(count_reg);
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // assertions
    logic rsp_load;
    assign rsp_load = (state_reg == ST_DONE) && rsp_free;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= (CNT_W+1)'(CAPACITY))
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_INS_WR || state_reg == ST_INS_NEW ||
                   state_reg == ST_REM_WR))
        else $error("RAM write outside a shift or insert step");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && status_reg == STAT_FULL) |-> ({1'b0, count_reg} ==
                                                   (CNT_W+1)'(CAPACITY)))
        else $error("full status with room left");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_NEW) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("pending response changed");

endmodule

`default_nettype wire
